[sv/rpfs_pkg.sv]
// Package for the point rotation unit: fixed-point widths, turn constants,
// reciprocal constants and the structs passed between the front, queue and back.
// No dependencies.
`default_nettype none

package rpfs_pkg;

  // Field widths.
  localparam int COORD_W    = 24;  // Q16.8 coordinates
  localparam int DIFF_W     = 25;  // point minus pivot
  localparam int ANGLE_IN_W = 16;  // Q12.4 degrees
  localparam int ANGLE_W    = 13;  // reduced angle, 1/16 degree, (-2880, 2880]
  localparam int TRIG_W     = 16;  // Q2.14 sine and cosine, signed
  localparam int MAG_W      = 15;  // magnitude of a Q2.14 value
  localparam int FRAC_W     = 14;  // fraction bits of Q2.14

  // Angle units: 1/16 degree.
  localparam int HALF_TURN    = 2880;
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;

  // Angle reduction: the negated angle is biased so that it is never negative,
  // then whole turns are stripped by comparing against multiples of a turn.
  localparam int WRAP_TURNS    = 12;
  localparam int RED_W         = 17;
  localparam int REDUCE_OFFSET = (HALF_TURN - 1) + (WRAP_TURNS / 2) * FULL_TURN;

  // Parabola: 16*a*(2880-|a|)/2025, divided through a reciprocal.
  localparam int PAR_W         = 21;     // |a|*(2880-|a|) <= 1440*1440
  localparam int SINE_N_W      = 25;     // 16*PAR + half divisor
  localparam int SINE_DIV      = 2025;
  localparam int SINE_RECIP    = 16570;  // floor(2^25 / 2025)
  localparam int SINE_RECIP_W  = 15;
  localparam int SINE_RECIP_SH = 25;

  // Refinement term 9*g/40 is taken as ((9*g + 20) >> 3) / 5.
  localparam int REF_X_W      = 13;
  localparam int REF_H_W      = 11;
  localparam int DIV5_RECIP   = 52429;  // ceil(2^18 / 5)
  localparam int DIV5_RECIP_W = 16;
  localparam int DIV5_SH      = 18;
  localparam int REF_ROUND    = 20;

  localparam int Q14_HALF = 8192;

  // Rotation datapath widths.
  localparam int PROD_W = 41;
  localparam int SUM_W  = 42;
  localparam int QUO_W  = SUM_W - FRAC_W;
  localparam int RES_W  = QUO_W + 1;

  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // Pipeline depths of the back part.
  localparam int SINE_LAT = 6;
  localparam int ROT_LAT  = 4;
  localparam int BACK_LAT = SINE_LAT + ROT_LAT;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified item, as it waits in the queue.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] sin_ang;
    logic signed [ANGLE_W-1:0] cos_ang;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
  } job_t;

  // Data that rides along the sine pipeline.
  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
  } side_t;

  // Queue status seen by both neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[sv/rpfs_fifo.sv]
// Short queue between the front and back parts of the rotation unit.
// Register-based storage; depends on rpfs_pkg for the status struct.
`default_nettype none

module rpfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output rpfs_pkg::q_status_t   status
);
  import rpfs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata        = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

[sv/rpfs_front.sv]
// Front part of the rotation unit: takes items, reduces the angle, forms the
// point-to-pivot offsets and hands one job to the queue. Depends on rpfs_pkg.
`default_nettype none

module rpfs_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    point_x,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    point_y,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    pivot_x,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    pivot_y,
  input  logic signed [rpfs_pkg::ANGLE_IN_W-1:0] angle_deg,
  input  rpfs_pkg::q_status_t                    q_status,
  output logic                                   push,
  output rpfs_pkg::job_t                         job
);
  import rpfs_pkg::*;

  logic                      vld, vld_next;
  logic                      accept;
  logic signed [RED_W-1:0]   neg_ang;
  logic        [RED_W-1:0]   biased;
  logic        [RED_W-1:0]   rem;
  logic        [ANGLE_W-1:0] sin_raw;
  logic signed [ANGLE_W-1:0] sin_ang;
  logic signed [ANGLE_W:0]   cos_wide;
  job_t                      job_next;

  // Reduce -angle into (-180, 180] degrees. The bias makes the value positive
  // and lands the result on [0, 5760) after whole turns are stripped.
  always_comb begin
    neg_ang = -RED_W'(angle_deg);
    biased  = unsigned'(neg_ang) + RED_W'(REDUCE_OFFSET);
    rem     = biased;
    for (int j = 1; j <= WRAP_TURNS; j++) begin
      if (biased >= RED_W'(j * FULL_TURN)) begin
        rem = biased - RED_W'(j * FULL_TURN);
      end
    end
    sin_raw  = ANGLE_W'(rem) - ANGLE_W'(HALF_TURN - 1);
    sin_ang  = signed'(sin_raw);
    // Cosine angle: a quarter turn ahead, wrapped past the half turn.
    cos_wide = (ANGLE_W + 1)'(sin_ang) + (ANGLE_W + 1)'(QUARTER_TURN);
    if (cos_wide > (ANGLE_W + 1)'(HALF_TURN)) begin
      cos_wide = cos_wide - (ANGLE_W + 1)'(FULL_TURN);
    end

    job_next.sin_ang = sin_ang;
    job_next.cos_ang = cos_wide[ANGLE_W-1:0];
    job_next.dx      = DIFF_W'(point_x) - DIFF_W'(pivot_x);
    job_next.dy      = DIFF_W'(pivot_y) - DIFF_W'(point_y);
    job_next.pivot_x = pivot_x;
    job_next.pivot_y = pivot_y;
  end

  assign in_stall = vld & q_status.full;
  assign accept   = in_valid & ~in_stall;
  assign push     = vld & ~q_status.full;

  always_comb begin
    vld_next = vld;
    if (accept) begin
      vld_next = 1'b1;
    end else if (push) begin
      vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

[sv/rpfs_sine.sv]
// Six-stage parabolic sine: Q2.14 sine of an angle in 1/16 degree units.
// Advances only when enabled. Depends on rpfs_pkg.
`default_nettype none

module rpfs_sine (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rpfs_pkg::ANGLE_W-1:0] angle,
  output logic signed [rpfs_pkg::TRIG_W-1:0]  sine
);
  import rpfs_pkg::*;

  localparam int SQ_W   = 2 * MAG_W;
  localparam int NINE_W = MAG_W + 3;
  localparam int P6_W   = REF_X_W + DIV5_RECIP_W + 1;
  localparam int P2_W   = SINE_N_W + SINE_RECIP_W;

  // Stage 1 signals.
  logic [ANGLE_W-1:0]   abs_ang;
  logic [ANGLE_W-2:0]   mag;
  logic [ANGLE_W-2:0]   comp;
  logic [2*ANGLE_W-3:0] prod1;
  logic [PAR_W-1:0]     m1;
  logic                 sgn1;
  // Stage 2.
  logic [SINE_N_W-1:0]  n;
  logic [P2_W-1:0]      prod2;
  logic [SINE_N_W-1:0]  n2;
  logic [MAG_W-1:0]     q0;
  logic                 sgn2;
  // Stage 3.
  logic [SINE_N_W:0]    qm;
  logic [SINE_N_W:0]    rem;
  logic [MAG_W-1:0]     smag3;
  logic                 sgn3;
  // Stage 4.
  logic [SQ_W-1:0]      sq;
  logic [SQ_W-1:0]      sq_rnd;
  logic [MAG_W-1:0]     smag4;
  logic [MAG_W-1:0]     pmag4;
  logic                 sgn4;
  // Stage 5.
  logic [MAG_W-1:0]     g;
  logic [NINE_W-1:0]    nine;
  logic [REF_X_W-1:0]   x5;
  logic [MAG_W-1:0]     smag5;
  logic                 sgn5;
  // Stage 6.
  logic [P6_W-1:0]      prod6;
  logic [MAG_W-1:0]     v;

  always_comb begin
    abs_ang = angle[ANGLE_W-1] ? -angle : angle;
    mag     = abs_ang[ANGLE_W-2:0];
    comp    = (ANGLE_W - 1)'(HALF_TURN) - mag;
    prod1   = (2 * ANGLE_W - 2)'(mag) * (2 * ANGLE_W - 2)'(comp);

    n     = {m1, 4'b0000} + SINE_N_W'(SINE_DIV / 2);
    prod2 = P2_W'(n) * P2_W'(SINE_RECIP);

    qm  = (SINE_N_W + 1)'(q0) * (SINE_N_W + 1)'(SINE_DIV);
    rem = (SINE_N_W + 1)'(n2) - qm;

    sq     = SQ_W'(smag3) * SQ_W'(smag3);
    sq_rnd = sq + SQ_W'(Q14_HALF);

    g    = smag4 - pmag4;
    nine = {g, 3'b000} + NINE_W'(g) + NINE_W'(REF_ROUND);

    prod6 = P6_W'(x5) * P6_W'(DIV5_RECIP);
    v     = smag5 - MAG_W'(prod6[DIV5_SH +: REF_H_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= prod1[PAR_W-1:0];
      sgn1  <= angle[ANGLE_W-1];

      q0    <= prod2[SINE_RECIP_SH +: MAG_W];
      n2    <= n;
      sgn2  <= sgn1;

      smag3 <= q0 + MAG_W'(rem >= (SINE_N_W + 1)'(SINE_DIV));
      sgn3  <= sgn2;

      pmag4 <= sq_rnd[FRAC_W +: MAG_W];
      smag4 <= smag3;
      sgn4  <= sgn3;

      x5    <= nine[3 +: REF_X_W];
      smag5 <= smag4;
      sgn5  <= sgn4;

      sine  <= sgn5 ? -TRIG_W'(v) : TRIG_W'(v);
    end
  end

endmodule

`default_nettype wire

[sv/rpfs_back.sv]
// Back part of the rotation unit: sine and cosine lanes, the rotation
// products, rounding, pivot add and saturation. Depends on rpfs_pkg, rpfs_sine.
`default_nettype none

module rpfs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  rpfs_pkg::q_status_t                 q_status,
  input  rpfs_pkg::job_t                      job,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpfs_pkg::COORD_W-1:0] rotated_x,
  output logic signed [rpfs_pkg::COORD_W-1:0] rotated_y
);
  import rpfs_pkg::*;

  logic                      en;
  logic [BACK_LAT-1:0]       vld, vld_next;
  logic signed [TRIG_W-1:0]  sn, cs;
  side_t                     side_d [SINE_LAT];
  side_t                     side_in;
  side_t                     side_q;

  logic signed [PROD_W-1:0]  p_cdx, p_sdy, p_sdx, p_cdy;
  logic signed [COORD_W-1:0] cx1, cy1, cx2, cy2, cx3, cy3;
  logic signed [SUM_W-1:0]   sx, sy;
  logic signed [SUM_W-1:0]   rnd_x, rnd_y;
  logic signed [QUO_W-1:0]   qx, qy;
  logic signed [RES_W-1:0]   rx, ry;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [RES_W-1:0] val);
    logic signed [COORD_W-1:0] res;
    if (val > RES_W'(COORD_MAX)) begin
      res = COORD_W'(COORD_MAX);
    end else if (val < RES_W'(COORD_MIN)) begin
      res = COORD_W'(COORD_MIN);
    end else begin
      res = val[COORD_W-1:0];
    end
    return res;
  endfunction

  // The whole back pipeline moves together; it holds only when the result
  // in the output register is being stalled.
  assign en        = ~(vld[BACK_LAT-1] & out_stall);
  assign pop       = en & ~q_status.empty;
  assign out_valid = vld[BACK_LAT-1];

  always_comb begin
    vld_next = vld;
    if (en) begin
      vld_next = {vld[BACK_LAT-2:0], ~q_status.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  rpfs_sine u_sin (
    .clk   (clk),
    .en    (en),
    .angle (job.sin_ang),
    .sine  (sn)
  );

  rpfs_sine u_cos (
    .clk   (clk),
    .en    (en),
    .angle (job.cos_ang),
    .sine  (cs)
  );

  assign side_in.dx      = job.dx;
  assign side_in.dy      = job.dy;
  assign side_in.pivot_x = job.pivot_x;
  assign side_in.pivot_y = job.pivot_y;
  assign side_q          = side_d[SINE_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_in;
      for (int i = 1; i < SINE_LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // Round to nearest with ties away from zero: a negative sum takes one less
  // than half before the arithmetic shift.
  always_comb begin
    rnd_x = sx + (sx[SUM_W-1] ? SUM_W'(Q14_HALF - 1) : SUM_W'(Q14_HALF));
    rnd_y = sy + (sy[SUM_W-1] ? SUM_W'(Q14_HALF - 1) : SUM_W'(Q14_HALF));
    rx    = RES_W'(cx3) + RES_W'(qx);
    ry    = RES_W'(cy3) - RES_W'(qy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cdx <= PROD_W'(cs) * PROD_W'(side_q.dx);
      p_sdy <= PROD_W'(sn) * PROD_W'(side_q.dy);
      p_sdx <= PROD_W'(sn) * PROD_W'(side_q.dx);
      p_cdy <= PROD_W'(cs) * PROD_W'(side_q.dy);
      cx1   <= side_q.pivot_x;
      cy1   <= side_q.pivot_y;

      sx    <= SUM_W'(p_cdx) - SUM_W'(p_sdy);
      sy    <= SUM_W'(p_sdx) + SUM_W'(p_cdy);
      cx2   <= cx1;
      cy2   <= cy1;

      qx    <= QUO_W'(rnd_x >>> FRAC_W);
      qy    <= QUO_W'(rnd_y >>> FRAC_W);
      cx3   <= cx2;
      cy3   <= cy2;

      rotated_x <= sat(rx);
      rotated_y <= sat(ry);
    end
  end

endmodule

`default_nettype wire

[sv/rotate_point_fast_sine_unit.sv]
// Top level of the point rotation unit with parabolic sine.
// Depends on rpfs_pkg, rpfs_front, rpfs_fifo and rpfs_back.
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   point_x, point_y, pivot_x, pivot_y, angle_deg
// output    out_valid / out_stall rotated_x, rotated_y
//
// One item is accepted per cycle and one result leaves per cycle when neither
// side stalls. From acceptance, an item passes through the front register, the
// queue and the back pipeline: the sine and cosine lanes, then the multiply,
// sum, round and saturate stages. Reset clears only the valid flags, the queue
// pointers and the queue count. A stalled output holds the whole back
// pipeline; the queue then fills and the input stalls.
//
// The angle is negated and reduced into (-180, 180] degrees, sine and cosine
// come from the parabolic approximation with its refinement term, and the
// point is rotated about the pivot in a y-down frame:
//   x' = PX + cos*dx - sin*dy,  y' = PY - sin*dx - cos*dy,
// with dx = X - PX and dy = PY - Y. Each output coordinate saturates.

module rotate_point_fast_sine_unit #(
  parameter int QUEUE_DEPTH = rpfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    point_x,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    point_y,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    pivot_x,
  input  logic signed [rpfs_pkg::COORD_W-1:0]    pivot_y,
  input  logic signed [rpfs_pkg::ANGLE_IN_W-1:0] angle_deg,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rpfs_pkg::COORD_W-1:0]   rotated_x,
  output logic signed [rpfs_pkg::COORD_W-1:0]   rotated_y
);
  import rpfs_pkg::*;

  localparam int JOB_W = $bits(job_t);

  q_status_t        q_status;
  logic             push;
  logic             pop;
  job_t             front_job;
  job_t             back_job;
  logic [JOB_W-1:0] q_rdata;

  // Front: classifies each item (angle reduction, offsets) into a job.
  rpfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .angle_deg (angle_deg),
    .q_status  (q_status),
    .push      (push),
    .job       (front_job)
  );

  // Queue: decouples the front from stalls in the back.
  rpfs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (front_job),
    .pop    (pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  assign back_job = job_t'(q_rdata);

  // Back: trig lanes and the rotation itself, ending in the output register.
  rpfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .job       (back_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for rotate_point_fast_sine_unit.
// It needs rpfs_pkg and the unit RTL. A directed table comes first, then random
// points, all checked against typed-in results or a fixed-point predictor.

module testbench;

  import rpfs_pkg::*;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [ANGLE_IN_W-1:0] angle_t;

  // One input item. A row with known_result set carries its own result,
  // typed in by hand; all other items get their result from the predictor.
  typedef struct {
    coord_t px;
    coord_t py;
    coord_t cx;
    coord_t cy;
    angle_t ang;
    bit     known_result;
    coord_t ex;
    coord_t ey;
  } point_item_t;

  // One rotated point, tagged with the number of the item that caused it.
  typedef struct {
    coord_t x;
    coord_t y;
    int     idx;
  } rotated_t;

  localparam int NUM_DIR      = 21;
  localparam int PHASE_ITEMS  = 534;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = BACK_LAT + 8;
  // The limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT  = 400000;

  localparam coord_t C_MAX = coord_t'(COORD_MAX);
  localparam coord_t C_MIN = coord_t'(COORD_MIN);

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t point_x;
  coord_t point_y;
  coord_t pivot_x;
  coord_t pivot_y;
  angle_t angle_deg;
  logic   out_valid;
  logic   out_stall;
  coord_t rotated_x;
  coord_t rotated_y;

  rotate_point_fast_sine_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .angle_deg (angle_deg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y)
  );

  // Results that are expected but not yet seen, oldest first.
  rotated_t pending_points[$];

  int  items_sent    = 0;
  int  results_seen  = 0;
  int  error_count   = 0;
  int  cycle_count   = 0;
  // Idle rates in percent, set by the stimulus process for each phase.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  // Set by the stimulus process to ask the receiver for one long hold-off.
  bit  hold_request  = 1'b0;

  point_item_t dir_tab [0:NUM_DIR-1];

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Division by a positive value, rounded to nearest with ties away from
  // zero. SystemVerilog division truncates toward zero, so the sign is
  // handled outside.
  function automatic longint round_div(longint num, longint den);
    if (num < 0)
      return -((-num + den / 2) / den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Parabolic sine of an angle in 1/16 degree within [-180, 180] degrees,
  // with the refinement term, in Q2.14.
  function automatic longint parabolic_sine(longint a);
    longint s;
    longint p;
    s = round_div(16 * a * (HALF_TURN - magnitude(a)), SINE_DIV);
    p = round_div(s * magnitude(s), 1 << FRAC_W);
    return s + round_div(9 * (p - s), 40);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX)
      v = COORD_MAX;
    else if (v < COORD_MIN)
      v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic rotated_t predict_rotation(point_item_t it);
    longint   px;
    longint   py;
    longint   cx;
    longint   cy;
    longint   a;
    longint   b;
    longint   sn;
    longint   cs;
    longint   dx;
    longint   dy;
    rotated_t r;
    px = it.px;
    py = it.py;
    cx = it.cx;
    cy = it.cy;
    // Negate, then reduce into (-180, 180] degrees.
    a = (-longint'(it.ang)) % FULL_TURN;
    if (a < 0)
      a += FULL_TURN;
    if (a > HALF_TURN)
      a -= FULL_TURN;
    // Cosine is the sine a quarter turn on, wrapped back into range.
    b = a + QUARTER_TURN;
    if (b > HALF_TURN)
      b -= FULL_TURN;
    sn = parabolic_sine(a);
    cs = parabolic_sine(b);
    // Screen frame: y grows downward.
    dx = px - cx;
    dy = cy - py;
    r.x = clamp_coord(cx + round_div(cs * dx - sn * dy, 1 << FRAC_W));
    r.y = clamp_coord(cy - round_div(sn * dx + cs * dy, 1 << FRAC_W));
    r.idx = 0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic point_item_t make_row(coord_t px, coord_t py, coord_t cx, coord_t cy,
                                           int ang, bit known, coord_t ex, coord_t ey);
    point_item_t it;
    it.px = px;
    it.py = py;
    it.cx = cx;
    it.cy = cy;
    it.ang = angle_t'(ang);
    it.known_result = known;
    it.ex = ex;
    it.ey = ey;
    return it;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_offset(coord_t base, int span);
    return coord_t'(longint'(base) + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random item. Four in ten items are fully random; the rest keep the point
  // near the pivot, sit close to right angles, stay small, or use extremes, so
  // that both saturated and unsaturated results are common.
  function automatic point_item_t random_item();
    point_item_t it;
    int          k;
    it.known_result = 1'b0;
    it.ex = '0;
    it.ey = '0;
    it.px = coord_t'($urandom);
    it.py = coord_t'($urandom);
    it.cx = coord_t'($urandom);
    it.cy = coord_t'($urandom);
    it.ang = angle_t'($urandom);
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        it.px = near_offset(it.cx, 65536);
        it.py = near_offset(it.cy, 65536);
      end
      7: begin
        k = $urandom_range(0, 44);
        it.ang = angle_t'((k - 22) * QUARTER_TURN + int'($urandom_range(0, 4)) - 2);
      end
      8: begin
        it.px = near_offset('0, 4096);
        it.py = near_offset('0, 4096);
        it.cx = near_offset('0, 4096);
        it.cy = near_offset('0, 4096);
      end
      9: begin
        it.px = pick_extreme();
        it.py = pick_extreme();
        it.cx = pick_extreme();
        it.cy = pick_extreme();
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic report_fault(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Offers one item, starting at a falling edge, and returns at the falling
  // edge after it was taken. Random idle cycles come first.
  task automatic offer_point(input point_item_t it);
    rotated_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    point_x   <= it.px;
    point_y   <= it.py;
    pivot_x   <= it.cx;
    pivot_y   <= it.cy;
    angle_deg <= it.ang;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (it.known_result) begin
      want.x = it.ex;
      want.y = it.ey;
    end else begin
      want = predict_rotation(it);
    end
    want.idx = items_sent;
    pending_points.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count)
      offer_point(random_item());
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset and the main sequence
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    point_x   = '0;
    point_y   = '0;
    pivot_x   = '0;
    pivot_y   = '0;
    angle_deg = '0;

    // Directed rows. Angle zero and a full turn leave the point where it is,
    // a point on its pivot stays there, and a half turn mirrors the point
    // through the pivot, which with opposite extremes saturates.
    dir_tab = '{
      make_row('0, '0, '0, '0, 0, 1'b1, '0, '0),
      make_row(coord_t'(25728), coord_t'(-1000), '0, '0, 0, 1'b1,
               coord_t'(25728), coord_t'(-1000)),
      make_row(C_MAX, C_MIN, C_MIN, C_MAX, 0, 1'b1, C_MAX, C_MIN),
      make_row(C_MIN, C_MAX, C_MAX, C_MIN, HALF_TURN, 1'b1, C_MAX, C_MIN),
      make_row(C_MIN, C_MAX, C_MAX, C_MIN, -HALF_TURN, 1'b1, C_MAX, C_MIN),
      make_row(C_MAX, C_MAX, C_MIN, C_MIN, HALF_TURN, 1'b1, C_MIN, C_MIN),
      make_row(coord_t'(12345), coord_t'(-6789), coord_t'(12345), coord_t'(-6789), 600,
               1'b1, coord_t'(12345), coord_t'(-6789)),
      make_row(coord_t'(5000), coord_t'(7000), coord_t'(-300), coord_t'(200), FULL_TURN,
               1'b1, coord_t'(5000), coord_t'(7000)),
      make_row(coord_t'(25600), coord_t'(0), '0, '0, QUARTER_TURN, 1'b0, '0, '0),
      make_row(coord_t'(25600), coord_t'(12800), coord_t'(256), '0, -QUARTER_TURN,
               1'b0, '0, '0),
      // Cosine wrap: the reduced angle plus a quarter turn passes 180 degrees.
      make_row(coord_t'(25600), coord_t'(-12800), '0, coord_t'(512), -QUARTER_TURN - 1,
               1'b0, '0, '0),
      make_row(coord_t'(-40000), coord_t'(30000), coord_t'(1000), coord_t'(-2000), -2000,
               1'b0, '0, '0),
      make_row(coord_t'(300000), coord_t'(-200000), '0, '0, 32767, 1'b0, '0, '0),
      make_row(coord_t'(-300000), coord_t'(200000), '0, '0, -32768, 1'b0, '0, '0),
      make_row(coord_t'(1000000), coord_t'(1000000), '0, '0, 1, 1'b0, '0, '0),
      make_row(coord_t'(1000000), coord_t'(1000000), '0, '0, -1, 1'b0, '0, '0),
      make_row(coord_t'(65536), coord_t'(65536), coord_t'(-65536), '0, 720, 1'b0, '0, '0),
      make_row(coord_t'(77777), coord_t'(-88888), coord_t'(111), coord_t'(222),
               HALF_TURN - 1, 1'b0, '0, '0),
      make_row(coord_t'(77777), coord_t'(-88888), coord_t'(111), coord_t'(222),
               HALF_TURN + 1, 1'b0, '0, '0),
      // Quarter turn about an extreme pivot pushes the result out of range.
      make_row(C_MIN, C_MIN, C_MAX, C_MAX, QUARTER_TURN, 1'b0, '0, '0),
      make_row(C_MAX, '0, C_MIN, '0, -QUARTER_TURN, 1'b0, '0, '0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with light idling on both sides.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    for (int i = 0; i < NUM_DIR; i++)
      offer_point(dir_tab[i]);
    wait_drained();

    // Random part, phase one: the sender idles less than the receiver.
    send_idle_pct = 31;
    recv_idle_pct = 60;
    run_random(PHASE_ITEMS);
    // The sender pauses here until every expected result has come.
    wait_drained();

    // Phase two: the idle rates are swapped.
    send_idle_pct = 60;
    recv_idle_pct = 31;
    run_random(PHASE_ITEMS);

    // Phase three: no idling. The receiver first holds off for a long
    // stretch, so the pipeline and queue fill and the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d directed rows and three random phases (sender idle,",
             items_sent, NUM_DIR);
    $display("receiver idle, none) with a long output hold; %0d results checked, %0d errors.",
             results_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: drives out_stall at the falling edge. A hold-off request from
  // the main sequence turns into one continuous stall, counted down here;
  // otherwise the stall follows the idle rate of the current phase.
  // ---------------------------------------------------------------------

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: at each rising edge where a result is taken, compare it
  // with the oldest expectation, field by field.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    rotated_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_points.size() == 0) begin
        report_fault($sformatf("result (%0d, %0d) with no item waiting",
                               rotated_x, rotated_y));
      end else begin
        want = pending_points.pop_front();
        if (rotated_x !== want.x)
          report_fault($sformatf("item %0d rotated_x got %0d expected %0d",
                                 want.idx, rotated_x, want.x));
        if (rotated_y !== want.y)
          report_fault($sformatf("item %0d rotated_y got %0d expected %0d",
                                 want.idx, rotated_y, want.y));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_points.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
